/* sv/vng_pkg.sv */
// vng_pkg: shared types and constants of the vertex normal generator
// no dependencies
package vng_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int C_W = 36;
    localparam int ACC_W = 20;
    localparam int N_W = 16;

    localparam logic [ACC_W-1:0] ACC_MAX = 20'h7FFFF;
    localparam logic [ACC_W-1:0] ACC_MIN = 20'h80000;
    localparam logic [N_W-1:0] ONE_Q14 = 16'd16384;
    localparam logic [5:0] FACE_EPS_SQ = 6'd43;
    localparam logic [5:0] VERT_EPS_SQ = 6'd3;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_FACE  = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    localparam logic RES_FACE = 1'b0;
    localparam logic RES_READ = 1'b1;

    typedef struct packed {
        t_kind              kind;
        logic [9:0]         vertex_index;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic               face_last;
    } t_in_item;

    typedef struct packed {
        logic               result_kind;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
    } t_out_item;

    typedef logic [2:0][C_W-1:0] t_cvec;
    typedef logic [2:0][N_W-1:0] t_nvec;

endpackage

/* sv/vng_norm.sv */
// vng_norm: vector normalizer, bit-serial square root and restoring divide
// depends on vng_pkg
module vng_norm import vng_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_cvec      i_c,
    input  logic [5:0] i_eps,
    output logic       o_done,
    output t_nvec      o_n
);

    typedef enum logic [6:0] {
        N_IDLE  = 7'b0000001,
        N_SHIFT = 7'b0000010,
        N_SQ    = 7'b0000100,
        N_CHK   = 7'b0001000,
        N_SQRT  = 7'b0010000,
        N_DLOAD = 7'b0100000,
        N_DIV   = 7'b1000000
    } t_nstate;

    t_nstate          r_state;
    logic [C_W-1:0]   r_m [3];
    logic [2:0]       r_neg;
    logic             r_shifted;
    logic [1:0]       r_k;
    logic [61:0]      r_prod;
    logic [63:0]      r_s;
    logic [63:0]      r_rs;
    logic [63:0]      r_rr;
    logic [63:0]      r_bit;
    logic [4:0]       r_cnt;
    logic [31:0]      r_rem;
    logic [14:0]      r_dbits;
    logic [14:0]      r_q;
    logic [3:0]       r_j;
    logic [N_W-1:0]   r_n [3];
    logic             r_done;

    logic [30:0]      m_sel;
    logic [31:0]      len;
    logic [32:0]      t_div;
    logic             ge;
    logic [14:0]      q_fin;
    logic [45:0]      numer;
    logic [63:0]      rr_bit;

    always_comb begin
        case (r_k)
            2'd0:    m_sel = r_m[0][30:0];
            2'd1:    m_sel = r_m[1][30:0];
            2'd2:    m_sel = r_m[2][30:0];
            default: m_sel = '0;
        endcase
        len    = r_rr[31:0];
        t_div  = {r_rem, r_dbits[14]};
        ge     = t_div >= {1'b0, len};
        q_fin  = {r_q[13:0], ge};
        numer  = {m_sel, 14'b0} + {15'b0, len[31:1]};
        rr_bit = r_rr + r_bit;
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= N_IDLE;
        end else begin
            unique case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        for (int i = 0; i < 3; i++) begin
                            r_neg[i] <= i_c[i][C_W-1];
                            r_m[i]   <= i_c[i][C_W-1] ? C_W'(-i_c[i]) : i_c[i];
                        end
                        r_shifted <= 1'b0;
                        r_state   <= N_SHIFT;
                    end
                end
                N_SHIFT: begin
                    if (r_m[0][C_W-1:31] != '0 || r_m[1][C_W-1:31] != '0 ||
                        r_m[2][C_W-1:31] != '0) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                        r_shifted <= 1'b1;
                    end else begin
                        r_k     <= '0;
                        r_s     <= '0;
                        r_state <= N_SQ;
                    end
                end
                N_SQ: begin
                    r_prod <= m_sel * m_sel;
                    if (r_k != 2'd0) r_s <= r_s + {2'b0, r_prod};
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) r_state <= N_CHK;
                end
                N_CHK: begin
                    if (!r_shifted && r_s < {58'b0, i_eps}) begin
                        r_n[0]  <= '0;
                        r_n[1]  <= '0;
                        r_n[2]  <= ONE_Q14;
                        r_done  <= 1'b1;
                        r_state <= N_IDLE;
                    end else begin
                        r_rs    <= r_s;
                        r_rr    <= '0;
                        r_bit   <= 64'h4000_0000_0000_0000;
                        r_cnt   <= '0;
                        r_state <= N_SQRT;
                    end
                end
                N_SQRT: begin
                    if (r_rs >= rr_bit) begin
                        r_rs <= r_rs - rr_bit;
                        r_rr <= (r_rr >> 1) + r_bit;
                    end else begin
                        r_rr <= r_rr >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_k     <= '0;
                        r_state <= N_DLOAD;
                    end
                end
                N_DLOAD: begin
                    if (r_rr == '0) begin
                        r_n[0]  <= '0;
                        r_n[1]  <= '0;
                        r_n[2]  <= ONE_Q14;
                        r_done  <= 1'b1;
                        r_state <= N_IDLE;
                    end else begin
                        r_rem   <= {1'b0, numer[45:15]};
                        r_dbits <= numer[14:0];
                        r_q     <= '0;
                        r_j     <= '0;
                        r_state <= N_DIV;
                    end
                end
                N_DIV: begin
                    if (ge) r_rem <= 32'(t_div - {1'b0, len});
                    else    r_rem <= t_div[31:0];
                    r_dbits <= r_dbits << 1;
                    r_q     <= q_fin;
                    r_j     <= r_j + 4'd1;
                    if (r_j == 4'd14) begin
                        r_n[r_k] <= r_neg[r_k] ? N_W'(-{1'b0, q_fin}) : {1'b0, q_fin};
                        if (r_k == 2'd2) begin
                            r_done  <= 1'b1;
                            r_state <= N_IDLE;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= N_DLOAD;
                        end
                    end
                end
                default: r_state <= N_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_n[0] = r_n[0];
    assign o_n[1] = r_n[1];
    assign o_n[2] = r_n[2];

endmodule

/* sv/vertex_normal_generator.sv */
// vertex_normal_generator: position store, normal accumulators and face sequencer
// depends on vng_pkg and vng_norm
//
// usage: one command word is taken when start is high and busy is low.
// load words write the position store. a clear word drops any
// partial face and sweeps the accumulator memory, one entry per cycle, over
// all MAX_VERTICES entries; the same sweep runs after reset, with busy high.
// face words carry one vertex index each; the third index, when all three
// are in range, starts the edge cross product (six passes through one
// multiplier) and the normalizer, and each in-range vertex then takes a
// read-modify-write of its accumulator. a read word returns the normalized
// accumulator. the normalizer works through a shift, three squares, a
// 32-step bit-serial square root and three 15-step restoring divides.
// one word is in flight at a time. each result is shown for one cycle with
// o_strobe high; the receiver cannot stall it.
// the configuration channel is always ready and must only be written idle.
module vertex_normal_generator import vng_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_item    i_item,
    output logic        o_strobe,
    output t_out_item   o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam logic [16:0] MAXV = 17'(MAX_VERTICES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VERTICES - 1);

    typedef enum logic [13:0] {
        S_CLR  = 14'b00000000000001,
        S_IDLE = 14'b00000000000010,
        S_PRD0 = 14'b00000000000100,
        S_PRD1 = 14'b00000000001000,
        S_PRD2 = 14'b00000000010000,
        S_PRD3 = 14'b00000000100000,
        S_MUL  = 14'b00000001000000,
        S_NST  = 14'b00000010000000,
        S_NWT  = 14'b00000100000000,
        S_RD   = 14'b00001000000000,
        S_RDC  = 14'b00010000000000,
        S_ARD  = 14'b00100000000000,
        S_AWR  = 14'b01000000000000,
        S_EMIT = 14'b10000000000000
    } t_state;

    logic [47:0] pos_mem [MAX_VERTICES];
    logic [59:0] acc_mem [MAX_VERTICES];

    t_state             r_state;
    logic [AW-1:0]      r_sweep;
    logic [10:0]        r_vcount;
    logic [1:0]         r_fvc;
    logic [9:0]         r_fti0;
    logic [9:0]         r_fti1;
    logic [9:0]         r_alist [3];
    logic [1:0]         r_ai;
    logic [1:0]         r_acnt;
    logic               r_emit;
    logic               r_isread;
    logic [5:0]         r_eps;
    t_nvec              r_cfn;
    t_cvec              r_c;
    logic [47:0]        r_pos_rd;
    logic [59:0]        r_acc_rd;
    logic [47:0]        r_pa;
    logic [47:0]        r_pb;
    logic signed [16:0] r_e1 [3];
    logic signed [16:0] r_e2 [3];
    logic signed [33:0] r_prod;
    logic [2:0]         r_j;
    logic [2:0]         r_pj;
    logic               r_strobe;
    t_out_item          r_out;

    logic               accept;
    logic [9:0]         alist_cur;
    logic               pos_we;
    logic [AW-1:0]      pos_raddr;
    logic               acc_we;
    logic [AW-1:0]      acc_waddr;
    logic [59:0]        acc_wdata;
    logic               norm_start;
    logic               norm_done;
    t_nvec              norm_n;
    logic signed [16:0] op_a;
    logic signed [16:0] op_b;
    logic               last_entry;

    function automatic logic [AW-1:0] to_addr(input logic [9:0] v);
        logic [16:0] e;
        e = {7'b0, v};
        return e[AW-1:0];
    endfunction

    function automatic logic in_range(input logic [9:0] v, input logic [10:0] cnt);
        return ({1'b0, v} < cnt) && ({7'b0, v} < MAXV);
    endfunction

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [N_W-1:0] b);
        logic [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {{(ACC_W-N_W+1){b[N_W-1]}}, b};
        if (s[ACC_W] != s[ACC_W-1]) return s[ACC_W] ? ACC_MIN : ACC_MAX;
        return s[ACC_W-1:0];
    endfunction

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;
    assign o_result    = r_out;
    assign alist_cur   = r_alist[r_ai];
    assign last_entry  = (r_ai + 2'd1) == r_acnt;
    assign norm_start  = (r_state == S_NST);

    always_comb begin
        pos_we    = accept && (i_item.kind == KIND_LOAD) &&
                    ({7'b0, i_item.vertex_index} < MAXV);
        acc_we    = (r_state == S_CLR) || (r_state == S_AWR);
        acc_waddr = (r_state == S_CLR) ? r_sweep : to_addr(alist_cur);
        acc_wdata = '0;
        if (r_state == S_AWR) begin
            acc_wdata = {sat_add(r_acc_rd[59:40], r_cfn[0]),
                         sat_add(r_acc_rd[39:20], r_cfn[1]),
                         sat_add(r_acc_rd[19:0], r_cfn[2])};
        end
        unique case (r_state)
            S_PRD0:  pos_raddr = to_addr(r_alist[0]);
            S_PRD1:  pos_raddr = to_addr(r_alist[1]);
            default: pos_raddr = to_addr(r_alist[2]);
        endcase
        case (r_j)
            3'd0:    begin op_a = r_e1[1]; op_b = r_e2[2]; end
            3'd1:    begin op_a = r_e1[2]; op_b = r_e2[1]; end
            3'd2:    begin op_a = r_e1[2]; op_b = r_e2[0]; end
            3'd3:    begin op_a = r_e1[0]; op_b = r_e2[2]; end
            3'd4:    begin op_a = r_e1[0]; op_b = r_e2[1]; end
            3'd5:    begin op_a = r_e1[1]; op_b = r_e2[0]; end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            pos_mem[to_addr(i_item.vertex_index)] <=
                {i_item.pos_x, i_item.pos_y, i_item.pos_z};
        end
        r_pos_rd <= pos_mem[pos_raddr];
        if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
        r_acc_rd <= acc_mem[to_addr(alist_cur)];
    end

    vng_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_start),
        .i_c     (r_c),
        .i_eps   (r_eps),
        .o_done  (norm_done),
        .o_n     (norm_n)
    );

    always_ff @(posedge i_clk) begin
        r_strobe <= 1'b0;
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_sweep  <= '0;
            r_vcount <= '0;
            r_fvc    <= '0;
            r_fti0   <= '0;
            r_fti1   <= '0;
            r_cfn    <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_vcount <= i_cfg_data;
            unique case (r_state)
                S_CLR: begin
                    r_sweep <= r_sweep + AW'(1);
                    if (r_sweep == LAST_ADDR) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (accept) begin
                        r_ai <= '0;
                        unique case (i_item.kind)
                            KIND_LOAD: ;
                            KIND_CLEAR: begin
                                r_fvc   <= '0;
                                r_sweep <= '0;
                                r_state <= S_CLR;
                            end
                            KIND_READ: begin
                                r_alist[0] <= i_item.vertex_index;
                                r_state    <= S_RD;
                            end
                            KIND_FACE: begin
                                r_emit <= i_item.face_last;
                                if (r_fvc == 2'd0 || r_fvc == 2'd1) begin
                                    if (r_fvc == 2'd0) r_fti0 <= i_item.vertex_index;
                                    else               r_fti1 <= i_item.vertex_index;
                                    r_alist[0] <= (r_fvc == 2'd0) ? i_item.vertex_index
                                                                  : r_fti0;
                                    r_alist[1] <= i_item.vertex_index;
                                    r_acnt     <= r_fvc + 2'd1;
                                    if (i_item.face_last) begin
                                        r_cfn[0] <= '0;
                                        r_cfn[1] <= '0;
                                        r_cfn[2] <= ONE_Q14;
                                        r_fvc    <= '0;
                                        r_state  <= S_ARD;
                                    end else begin
                                        r_fvc <= r_fvc + 2'd1;
                                    end
                                end else if (r_fvc == 2'd2) begin
                                    r_alist[0] <= r_fti0;
                                    r_alist[1] <= r_fti1;
                                    r_alist[2] <= i_item.vertex_index;
                                    r_acnt     <= 2'd3;
                                    r_fvc      <= i_item.face_last ? 2'd0 : 2'd3;
                                    if (in_range(r_fti0, r_vcount) &&
                                        in_range(r_fti1, r_vcount) &&
                                        in_range(i_item.vertex_index, r_vcount)) begin
                                        r_state <= S_PRD0;
                                    end else begin
                                        r_cfn[0] <= '0;
                                        r_cfn[1] <= '0;
                                        r_cfn[2] <= ONE_Q14;
                                        r_state  <= S_ARD;
                                    end
                                end else begin
                                    r_alist[0] <= i_item.vertex_index;
                                    r_acnt     <= 2'd1;
                                    r_fvc      <= i_item.face_last ? 2'd0 : 2'd3;
                                    r_state    <= S_ARD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_PRD0: r_state <= S_PRD1;
                S_PRD1: begin
                    r_pa    <= r_pos_rd;
                    r_state <= S_PRD2;
                end
                S_PRD2: begin
                    r_pb    <= r_pos_rd;
                    r_state <= S_PRD3;
                end
                S_PRD3: begin
                    // position layout is x high, z low: swap so index 0 is x
                    for (int i = 0; i < 3; i++) begin
                        r_e1[i] <= $signed({r_pb[16*(2-i)+15], r_pb[16*(2-i) +: 16]}) -
                                   $signed({r_pa[16*(2-i)+15], r_pa[16*(2-i) +: 16]});
                        r_e2[i] <= $signed({r_pos_rd[16*(2-i)+15],
                                            r_pos_rd[16*(2-i) +: 16]}) -
                                   $signed({r_pa[16*(2-i)+15], r_pa[16*(2-i) +: 16]});
                    end
                    r_c      <= '0;
                    r_j      <= '0;
                    r_isread <= 1'b0;
                    r_eps    <= FACE_EPS_SQ;
                    r_state  <= S_MUL;
                end
                S_MUL: begin
                    r_prod <= op_a * op_b;
                    r_pj   <= r_j;
                    r_j    <= r_j + 3'd1;
                    if (r_j != 3'd0) begin
                        case (r_pj)
                            3'd0: r_c[0] <= r_c[0] + {{2{r_prod[33]}}, r_prod};
                            3'd1: r_c[0] <= r_c[0] - {{2{r_prod[33]}}, r_prod};
                            3'd2: r_c[1] <= r_c[1] + {{2{r_prod[33]}}, r_prod};
                            3'd3: r_c[1] <= r_c[1] - {{2{r_prod[33]}}, r_prod};
                            3'd4: r_c[2] <= r_c[2] + {{2{r_prod[33]}}, r_prod};
                            3'd5: r_c[2] <= r_c[2] - {{2{r_prod[33]}}, r_prod};
                            default: ;
                        endcase
                    end
                    if (r_j == 3'd6) r_state <= S_NST;
                end
                S_NST: r_state <= S_NWT;
                S_NWT: begin
                    if (norm_done) begin
                        if (r_isread) begin
                            r_out.result_kind <= RES_READ;
                            r_out.norm_x      <= norm_n[0];
                            r_out.norm_y      <= norm_n[1];
                            r_out.norm_z      <= norm_n[2];
                            r_strobe          <= 1'b1;
                            r_state           <= S_IDLE;
                        end else begin
                            r_cfn   <= norm_n;
                            r_ai    <= '0;
                            r_state <= S_ARD;
                        end
                    end
                end
                S_RD: r_state <= S_RDC;
                S_RDC: begin
                    if (in_range(r_alist[0], r_vcount)) begin
                        r_c[0] <= {{(C_W-ACC_W){r_acc_rd[59]}}, r_acc_rd[59:40]};
                        r_c[1] <= {{(C_W-ACC_W){r_acc_rd[39]}}, r_acc_rd[39:20]};
                        r_c[2] <= {{(C_W-ACC_W){r_acc_rd[19]}}, r_acc_rd[19:0]};
                    end else begin
                        r_c <= '0;
                    end
                    r_isread <= 1'b1;
                    r_eps    <= VERT_EPS_SQ;
                    r_state  <= S_NST;
                end
                S_ARD: begin
                    if (in_range(alist_cur, r_vcount)) begin
                        r_state <= S_AWR;
                    end else if (last_entry) begin
                        r_state <= r_emit ? S_EMIT : S_IDLE;
                    end else begin
                        r_ai <= r_ai + 2'd1;
                    end
                end
                S_AWR: begin
                    if (last_entry) begin
                        r_state <= r_emit ? S_EMIT : S_IDLE;
                    end else begin
                        r_ai    <= r_ai + 2'd1;
                        r_state <= S_ARD;
                    end
                end
                S_EMIT: begin
                    r_out.result_kind <= RES_FACE;
                    r_out.norm_x      <= r_cfn[0];
                    r_out.norm_y      <= r_cfn[1];
                    r_out.norm_z      <= r_cfn[2];
                    r_strobe          <= 1'b1;
                    r_state           <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
